@@ rtl/edbd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Energy drop / breakdown detector package
// Shared widths, register indexes, reset values, event codes and sequencer states.
// ----------------------------------------------------------------------------
package edbd_pkg;

    localparam int SHORT_MAX  = 16;
    localparam int LONG_MAX   = 512;

    localparam int SHORT_AW   = $clog2(SHORT_MAX);
    localparam int LONG_AW    = $clog2(LONG_MAX);
    localparam int SWIN_W     = 5;
    localparam int CNT_W      = 10;
    localparam int ENERGY_W   = 16;
    localparam int TIME_W     = 32;
    localparam int EVENT_W    = 2;
    localparam int STOT_W     = 20;
    localparam int LTOT_W     = 25;
    localparam int PROD_W     = 30;
    localparam int RATIO_W    = 12;
    localparam int MUL_W      = PROD_W + RATIO_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WINDOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_WINDOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_FRAMES   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_MS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_RATIO      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BREAKDOWN_RATIO = 3'd5;

    localparam logic [SWIN_W-1:0]  RST_SHORT_WINDOW    = 5'd8;
    localparam logic [CNT_W-1:0]   RST_LONG_WINDOW     = 10'd256;
    localparam logic [CNT_W-1:0]   RST_WARMUP_FRAMES   = 10'd64;
    localparam logic [TIME_W-1:0]  RST_COOLDOWN_MS     = 32'd2000;
    localparam logic [RATIO_W-1:0] RST_DROP_RATIO      = 12'd384;
    localparam logic [RATIO_W-1:0] RST_BREAKDOWN_RATIO = 12'd128;

    localparam logic [EVENT_W-1:0] EV_NONE      = 2'd0;
    localparam logic [EVENT_W-1:0] EV_DROP      = 2'd1;
    localparam logic [EVENT_W-1:0] EV_BREAKDOWN = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_DROP,
        ST_MUL_BRK,
        ST_EVAL,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

@@ rtl/edbd_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Energy drop / breakdown detector channels
// Valid/ready interfaces for the frame input and the event output.
// ----------------------------------------------------------------------------
interface edbd_in_if;
    import edbd_pkg::*;

    logic                valid;
    logic                ready;
    logic [ENERGY_W-1:0] energy;
    logic [TIME_W-1:0]   time_ms;

    modport source (output valid, output energy, output time_ms, input ready);
    modport sink   (input valid, input energy, input time_ms, output ready);
endinterface

interface edbd_out_if;
    import edbd_pkg::*;

    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_res;

    modport source (output valid, output event_res, input ready);
    modport sink   (input valid, input event_res, output ready);
endinterface
`default_nettype wire

@@ rtl/energy_drop_breakdown_detector.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Energy drop / breakdown detector
// Short and long energy rings with running totals; the mean ratio is compared
// with the drop and breakdown thresholds through one shared multiplier.
// ----------------------------------------------------------------------------
// Sequence: an accepted frame passes ST_UPDATE, then the four passes through
// the shared multiplier in ST_MUL_A, ST_MUL_B, ST_MUL_DROP and ST_MUL_BRK,
// then ST_EVAL and ST_DONE; during warm-up, cooldown or silence it goes from
// ST_UPDATE to ST_DONE. Input is ready only in ST_IDLE, so frames do not overlap.
// Reset and window register writes clear all detector state at once; ring
// entries not yet written since then read as zero through the frame count.
module energy_drop_breakdown_detector (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    edbd_in_if.sink                              in_ch,
    edbd_out_if.source                           out_ch,
    input  wire logic                            cfg_we,
    input  wire logic [edbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [edbd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import edbd_pkg::*;

    state_t state_reg, state_next;

    logic [SWIN_W-1:0]   short_window_reg, short_window_next;
    logic [CNT_W-1:0]    long_window_reg, long_window_next;
    logic [CNT_W-1:0]    warmup_reg, warmup_next;
    logic [TIME_W-1:0]   cooldown_reg, cooldown_next;
    logic [RATIO_W-1:0]  drop_ratio_reg, drop_ratio_next;
    logic [RATIO_W-1:0]  brk_ratio_reg, brk_ratio_next;

    logic [SHORT_AW-1:0] short_pos_reg, short_pos_next;
    logic [LONG_AW-1:0]  long_pos_reg, long_pos_next;
    logic [CNT_W-1:0]    frames_reg, frames_next;
    logic [STOT_W-1:0]   short_total_reg, short_total_next;
    logic [LTOT_W-1:0]   long_total_reg, long_total_next;
    logic [TIME_W-1:0]   last_time_reg, last_time_next;
    logic                drop_armed_reg, drop_armed_next;
    logic                brk_armed_reg, brk_armed_next;

    logic [ENERGY_W-1:0] energy_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [PROD_W-1:0]   a_reg, a_next;
    logic [PROD_W-1:0]   b_reg, b_next;
    logic [MUL_W-1:0]    prod_reg, prod_next;
    logic                drop_hit_reg, drop_hit_next;
    logic [EVENT_W-1:0]  ev_reg, ev_next;
    logic                out_valid_reg, out_valid_next;
    logic [EVENT_W-1:0]  out_event_reg, out_event_next;

    logic [ENERGY_W-1:0] short_store_reg [SHORT_MAX];
    logic [ENERGY_W-1:0] long_rdata;

    logic [CNT_W-1:0]    lw;
    logic [SWIN_W-1:0]   sw_raw;
    logic [SWIN_W-1:0]   sw;
    logic [SHORT_AW-1:0] sp;
    logic [LONG_AW-1:0]  lp;
    logic [SWIN_W-1:0]   ns;
    logic [ENERGY_W-1:0] old_short;
    logic [ENERGY_W-1:0] old_long;
    logic [STOT_W-1:0]   short_total_upd;
    logic [LTOT_W-1:0]   long_total_upd;
    logic [CNT_W-1:0]    frames_upd;
    logic [TIME_W-1:0]   elapsed;
    logic                suppress;
    logic                in_xfer;
    logic                out_load;
    logic                cfg_clear;
    logic                upd_en;
    logic [PROD_W-1:0]   mul_a;
    logic [RATIO_W-1:0]  mul_b;
    logic [MUL_W-1:0]    mul_p;
    logic [MUL_W-1:0]    a_scaled;

    // Effective window lengths.
    assign lw = (long_window_reg == '0 || long_window_reg > CNT_W'(LONG_MAX))
                ? CNT_W'(LONG_MAX) : long_window_reg;
    assign sw_raw = (short_window_reg == '0 || short_window_reg > SWIN_W'(SHORT_MAX))
                    ? SWIN_W'(SHORT_MAX) : short_window_reg;
    assign sw = (CNT_W'(sw_raw) < lw) ? sw_raw : lw[SWIN_W-1:0];

    assign sp = (SWIN_W'(short_pos_reg) < sw) ? short_pos_reg : '0;
    assign lp = (CNT_W'(long_pos_reg) < lw) ? long_pos_reg : '0;
    assign ns = (frames_reg < CNT_W'(sw)) ? frames_reg[SWIN_W-1:0] : sw;

    assign in_xfer  = in_ch.valid && in_ch.ready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ch.ready);
    assign upd_en   = (state_reg == ST_UPDATE);
    assign cfg_clear = (state_reg == ST_IDLE) && cfg_we
                       && (cfg_index == CFG_SHORT_WINDOW || cfg_index == CFG_LONG_WINDOW);

    assign in_ch.ready      = (state_reg == ST_IDLE);
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.event_res = out_event_reg;

    // Entries beyond the frame count have not been written since the last clear.
    assign old_short = (CNT_W'(sp) < frames_reg) ? short_store_reg[sp] : '0;
    assign old_long  = (CNT_W'(lp) < frames_reg) ? long_rdata : '0;

    assign short_total_upd = short_total_reg - STOT_W'(old_short) + STOT_W'(energy_reg);
    assign long_total_upd  = long_total_reg - LTOT_W'(old_long) + LTOT_W'(energy_reg);
    assign frames_upd      = (frames_reg < lw) ? frames_reg + 1'b1 : frames_reg;
    assign elapsed         = now_reg - last_time_reg;
    assign suppress = (frames_upd < warmup_reg)
                      || (last_time_reg != '0 && elapsed < cooldown_reg)
                      || (long_total_upd == '0);

    edbd_ram #(
        .WIDTH (ENERGY_W),
        .DEPTH (LONG_MAX)
    ) u_long_ram (
        .clk   (clk),
        .we    (upd_en),
        .waddr (lp),
        .wdata (energy_reg),
        .raddr (lp),
        .rdata (long_rdata)
    );

    // Shared multiplier.
    always_comb
    begin
        case (state_reg)
            ST_MUL_A:
            begin
                mul_a = PROD_W'(short_total_reg);
                mul_b = RATIO_W'(frames_reg);
            end
            ST_MUL_B:
            begin
                mul_a = PROD_W'(long_total_reg);
                mul_b = RATIO_W'(ns);
            end
            ST_MUL_DROP:
            begin
                mul_a = b_reg;
                mul_b = drop_ratio_reg;
            end
            ST_MUL_BRK:
            begin
                mul_a = b_reg;
                mul_b = brk_ratio_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = MUL_W'(mul_a) * MUL_W'(mul_b);
    assign a_scaled = MUL_W'({a_reg, 8'd0});

    // Next state.
    always_comb
    begin
        case (state_reg)
            ST_IDLE:     state_next = in_xfer ? ST_UPDATE : ST_IDLE;
            ST_UPDATE:   state_next = suppress ? ST_DONE : ST_MUL_A;
            ST_MUL_A:    state_next = ST_MUL_B;
            ST_MUL_B:    state_next = ST_MUL_DROP;
            ST_MUL_DROP: state_next = ST_MUL_BRK;
            ST_MUL_BRK:  state_next = ST_EVAL;
            ST_EVAL:     state_next = ST_DONE;
            ST_DONE:     state_next = out_load ? ST_IDLE : ST_DONE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and register next values.
    always_comb
    begin
        short_window_next = short_window_reg;
        long_window_next  = long_window_reg;
        warmup_next       = warmup_reg;
        cooldown_next     = cooldown_reg;
        drop_ratio_next   = drop_ratio_reg;
        brk_ratio_next    = brk_ratio_reg;
        short_pos_next    = short_pos_reg;
        long_pos_next     = long_pos_reg;
        frames_next       = frames_reg;
        short_total_next  = short_total_reg;
        long_total_next   = long_total_reg;
        last_time_next    = last_time_reg;
        drop_armed_next   = drop_armed_reg;
        brk_armed_next    = brk_armed_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        prod_next         = prod_reg;
        drop_hit_next     = drop_hit_reg;
        ev_next           = ev_reg;
        out_valid_next    = out_valid_reg && !out_ch.ready;
        out_event_next    = out_event_reg;

        if ((state_reg == ST_IDLE) && cfg_we)
        begin
            case (cfg_index)
                CFG_SHORT_WINDOW:    short_window_next = cfg_data[SWIN_W-1:0];
                CFG_LONG_WINDOW:     long_window_next  = cfg_data[CNT_W-1:0];
                CFG_WARMUP_FRAMES:   warmup_next       = cfg_data[CNT_W-1:0];
                CFG_COOLDOWN_MS:     cooldown_next     = cfg_data[TIME_W-1:0];
                CFG_DROP_RATIO:      drop_ratio_next   = cfg_data[RATIO_W-1:0];
                CFG_BREAKDOWN_RATIO: brk_ratio_next    = cfg_data[RATIO_W-1:0];
                default:             ;
            endcase
        end

        if (cfg_clear)
        begin
            short_pos_next   = '0;
            long_pos_next    = '0;
            frames_next      = '0;
            short_total_next = '0;
            long_total_next  = '0;
            last_time_next   = '0;
            drop_armed_next  = 1'b1;
            brk_armed_next   = 1'b1;
        end

        case (state_reg)
            ST_UPDATE:
            begin
                short_total_next = short_total_upd;
                long_total_next  = long_total_upd;
                frames_next      = frames_upd;
                short_pos_next   = (SWIN_W'(sp) + 1'b1 == sw) ? '0 : sp + 1'b1;
                long_pos_next    = (CNT_W'(lp) + 1'b1 == lw) ? '0 : lp + 1'b1;
                ev_next          = EV_NONE;
            end
            ST_MUL_A:
            begin
                a_next = mul_p[PROD_W-1:0];
            end
            ST_MUL_B:
            begin
                b_next = mul_p[PROD_W-1:0];
            end
            ST_MUL_DROP:
            begin
                prod_next = mul_p;
                if (a_reg <= b_reg)
                begin
                    drop_armed_next = 1'b1;
                end
                if (a_reg >= b_reg)
                begin
                    brk_armed_next = 1'b1;
                end
            end
            ST_MUL_BRK:
            begin
                prod_next     = mul_p;
                drop_hit_next = a_scaled > prod_reg;
            end
            ST_EVAL:
            begin
                if (drop_hit_reg && drop_armed_reg)
                begin
                    ev_next         = EV_DROP;
                    drop_armed_next = 1'b0;
                    last_time_next  = now_reg;
                end
                else if ((a_scaled < prod_reg) && brk_armed_reg)
                begin
                    ev_next        = EV_BREAKDOWN;
                    brk_armed_next = 1'b0;
                    last_time_next = now_reg;
                end
                else
                begin
                    ev_next = EV_NONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_event_next = ev_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            short_window_reg <= RST_SHORT_WINDOW;
            long_window_reg  <= RST_LONG_WINDOW;
            warmup_reg       <= RST_WARMUP_FRAMES;
            cooldown_reg     <= RST_COOLDOWN_MS;
            drop_ratio_reg   <= RST_DROP_RATIO;
            brk_ratio_reg    <= RST_BREAKDOWN_RATIO;
            short_pos_reg    <= '0;
            long_pos_reg     <= '0;
            frames_reg       <= '0;
            short_total_reg  <= '0;
            long_total_reg   <= '0;
            last_time_reg    <= '0;
            drop_armed_reg   <= 1'b1;
            brk_armed_reg    <= 1'b1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            short_window_reg <= short_window_next;
            long_window_reg  <= long_window_next;
            warmup_reg       <= warmup_next;
            cooldown_reg     <= cooldown_next;
            drop_ratio_reg   <= drop_ratio_next;
            brk_ratio_reg    <= brk_ratio_next;
            short_pos_reg    <= short_pos_next;
            long_pos_reg     <= long_pos_next;
            frames_reg       <= frames_next;
            short_total_reg  <= short_total_next;
            long_total_reg   <= long_total_next;
            last_time_reg    <= last_time_next;
            drop_armed_reg   <= drop_armed_next;
            brk_armed_reg    <= brk_armed_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            energy_reg <= in_ch.energy;
            now_reg    <= in_ch.time_ms;
        end
        if (upd_en)
        begin
            short_store_reg[sp] <= energy_reg;
        end
        a_reg         <= a_next;
        b_reg         <= b_next;
        prod_reg      <= prod_next;
        drop_hit_reg  <= drop_hit_next;
        ev_reg        <= ev_next;
        out_event_reg <= out_event_next;
    end

    a_frames_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        frames_reg <= lw)
        else $error("frame count exceeds the long window");

    a_long_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(long_pos_reg) < lw)
        else $error("long ring position outside the window");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result presented without a finished frame");

    a_drop_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL && ev_next == EV_DROP) |=> !drop_armed_reg)
        else $error("drop event left the drop flag armed");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ch.ready)
        else $error("input taken while a frame is in progress");

endmodule
`default_nettype wire

@@ rtl/edbd_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module edbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Energy drop / breakdown detector testbench
// Drives frames through the input channel and checks each event against a
// local prediction of the short and long rings, or a fixed event for marked
// rows. Directed rows come first, then random frames under several settings.
// ----------------------------------------------------------------------------
module testbench;
    import edbd_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int N_PHASES      = 10;
    localparam int DIR_N         = 35;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef enum logic {ROW_FRAME, ROW_REG} row_kind_t;
    typedef enum logic {CHK_MODEL, CHK_FIXED} chk_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  value;
        logic [ENERGY_W-1:0]    energy;
        logic [TIME_W-1:0]      stamp;
        chk_t                   chk;
        logic [EVENT_W-1:0]     ev;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{ROW_FRAME, CFG_UNUSED, 32'h0, 16'hFFFF, 32'h0000_0000, CHK_FIXED, EV_NONE},
        '{ROW_FRAME, CFG_UNUSED, 32'h0, 16'h0000, 32'hFFFF_FFFF, CHK_FIXED, EV_NONE},
        '{ROW_REG, CFG_UNUSED, 32'hFFFF_FFFF, 16'h0, 32'h0, CHK_MODEL, EV_NONE},
        '{ROW_REG, CFG_WARMUP_FRAMES, 32'd0, 16'h0, 32'h0, CHK_MODEL, EV_NONE},
        '{ROW_REG, CFG_COOLDOWN_MS, 32'hFFFF_FFFF, 16'h0, 32'h0, CHK_MODEL, EV_NONE},
        '{ROW_REG, CFG_DROP_RATIO, 32'd0, 16'h0, 32'h0, CHK_MODEL, EV_NONE},
        '{ROW_REG, CFG_BREAKDOWN_RATIO, 32'hFFF, 16'h0, 32'h0, CHK_MODEL, EV_NONE},
        '{ROW_REG, CFG_SHORT_WINDOW, 32'd0, 16'h0, 32'h0, CHK_MODEL, EV_NONE},
        '{ROW_REG, CFG_LONG_WINDOW, 32'd0, 16'h0, 32'h0, CHK_MODEL, EV_NONE},
        '{ROW_FRAME, CFG_UNUSED, 32'h0, 16'd0, 32'd5, CHK_FIXED, EV_NONE},
        '{ROW_FRAME, CFG_UNUSED, 32'h0, 16'd1000, 32'd10, CHK_MODEL, EV_NONE},
        '{ROW_FRAME, CFG_UNUSED, 32'h0, 16'd2000, 32'd20, CHK_FIXED, EV_NONE},
        '{ROW_REG, CFG_COOLDOWN_MS, 32'd0, 16'h0, 32'h0, CHK_MODEL, EV_NONE},
        '{ROW_FRAME, CFG_UNUSED, 32'h0, 16'hFFFF, 32'd30, CHK_MODEL, EV_NONE},
        '{ROW_REG, CFG_SHORT_WINDOW, 32'd31, 16'h0, 32'h0, CHK_MODEL, EV_NONE},
        '{ROW_REG, CFG_LONG_WINDOW, 32'd3, 16'h0, 32'h0, CHK_MODEL, EV_NONE},
        '{ROW_REG, CFG_WARMUP_FRAMES, 32'd600, 16'h0, 32'h0, CHK_MODEL, EV_NONE},
        '{ROW_FRAME, CFG_UNUSED, 32'h0, 16'd500, 32'd100, CHK_FIXED, EV_NONE},
        '{ROW_FRAME, CFG_UNUSED, 32'h0, 16'd500, 32'd110, CHK_FIXED, EV_NONE},
        '{ROW_FRAME, CFG_UNUSED, 32'h0, 16'd500, 32'd120, CHK_FIXED, EV_NONE},
        '{ROW_FRAME, CFG_UNUSED, 32'h0, 16'd500, 32'd130, CHK_FIXED, EV_NONE},
        '{ROW_REG, CFG_WARMUP_FRAMES, 32'd1, 16'h0, 32'h0, CHK_MODEL, EV_NONE},
        '{ROW_REG, CFG_DROP_RATIO, 32'd384, 16'h0, 32'h0, CHK_MODEL, EV_NONE},
        '{ROW_REG, CFG_BREAKDOWN_RATIO, 32'd128, 16'h0, 32'h0, CHK_MODEL, EV_NONE},
        '{ROW_REG, CFG_COOLDOWN_MS, 32'd1000, 16'h0, 32'h0, CHK_MODEL, EV_NONE},
        '{ROW_REG, CFG_SHORT_WINDOW, 32'd2, 16'h0, 32'h0, CHK_MODEL, EV_NONE},
        '{ROW_REG, CFG_LONG_WINDOW, 32'd8, 16'h0, 32'h0, CHK_MODEL, EV_NONE},
        '{ROW_FRAME, CFG_UNUSED, 32'h0, 16'd100, 32'd200, CHK_MODEL, EV_NONE},
        '{ROW_FRAME, CFG_UNUSED, 32'h0, 16'd100, 32'd220, CHK_MODEL, EV_NONE},
        '{ROW_FRAME, CFG_UNUSED, 32'h0, 16'd100, 32'd240, CHK_MODEL, EV_NONE},
        '{ROW_FRAME, CFG_UNUSED, 32'h0, 16'd5000, 32'd0, CHK_MODEL, EV_NONE},
        '{ROW_FRAME, CFG_UNUSED, 32'h0, 16'd5000, 32'd50, CHK_MODEL, EV_NONE},
        '{ROW_FRAME, CFG_UNUSED, 32'h0, 16'd0, 32'd60, CHK_MODEL, EV_NONE},
        '{ROW_FRAME, CFG_UNUSED, 32'h0, 16'd0, 32'd70, CHK_MODEL, EV_NONE},
        '{ROW_FRAME, CFG_UNUSED, 32'h0, 16'd0, 32'd80, CHK_MODEL, EV_NONE}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    edbd_in_if  in_ch ();
    edbd_out_if out_ch ();

    energy_drop_breakdown_detector i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register copies.
    logic [SWIN_W-1:0]  reg_short_win;
    logic [CNT_W-1:0]   reg_long_win;
    logic [CNT_W-1:0]   reg_warmup;
    logic [TIME_W-1:0]  reg_cooldown;
    logic [RATIO_W-1:0] reg_drop;
    logic [RATIO_W-1:0] reg_brk;

    // Detector state.
    logic [ENERGY_W-1:0] sh_ring [SHORT_MAX];
    logic [ENERGY_W-1:0] lg_ring [LONG_MAX];
    logic [SHORT_AW-1:0] sh_wr;
    logic [LONG_AW-1:0]  lg_wr;
    logic [CNT_W-1:0]    seen_frames;
    logic [STOT_W-1:0]   sh_sum;
    logic [LTOT_W-1:0]   lg_sum;
    logic [TIME_W-1:0]   last_hit_ms;
    logic                drop_ready;
    logic                brk_ready;

    logic [EVENT_W-1:0] pending_events [$];
    chk_t               row_chk;
    logic [EVENT_W-1:0] row_ev;
    bit                 tx_idle_on;
    bit                 rx_idle_on;
    bit                 hold_req;
    int                 err_count = 0;
    int                 cycle_count = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void clear_detector();
        foreach (sh_ring[i]) sh_ring[i] = '0;
        foreach (lg_ring[i]) lg_ring[i] = '0;
        sh_wr       = '0;
        lg_wr       = '0;
        seen_frames = '0;
        sh_sum      = '0;
        lg_sum      = '0;
        last_hit_ms = '0;
        drop_ready  = 1'b1;
        brk_ready   = 1'b1;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_SHORT_WINDOW:
            begin
                reg_short_win = data[SWIN_W-1:0];
                clear_detector();
            end
            CFG_LONG_WINDOW:
            begin
                reg_long_win = data[CNT_W-1:0];
                clear_detector();
            end
            CFG_WARMUP_FRAMES:   reg_warmup   = data[CNT_W-1:0];
            CFG_COOLDOWN_MS:     reg_cooldown = data[TIME_W-1:0];
            CFG_DROP_RATIO:      reg_drop     = data[RATIO_W-1:0];
            CFG_BREAKDOWN_RATIO: reg_brk      = data[RATIO_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [EVENT_W-1:0] predict_event(input logic [ENERGY_W-1:0] e,
                                                         input logic [TIME_W-1:0] now);
        int unsigned        sw;
        int unsigned        lw;
        int unsigned        sp;
        int unsigned        lp;
        logic [63:0]        n_s;
        logic [63:0]        n_l;
        logic [63:0]        a;
        logic [63:0]        b;
        logic [TIME_W-1:0]  since;
        logic [EVENT_W-1:0] ev;
        lw = (reg_long_win == 0 || reg_long_win > LONG_MAX) ? LONG_MAX : reg_long_win;
        sw = (reg_short_win == 0 || reg_short_win > SHORT_MAX) ? SHORT_MAX : reg_short_win;
        if (sw > lw) sw = lw;
        sp = (sh_wr < sw) ? sh_wr : 0;
        lp = (lg_wr < lw) ? lg_wr : 0;
        sh_sum = sh_sum - sh_ring[sp] + e;
        sh_ring[sp] = e;
        lg_sum = lg_sum - lg_ring[lp] + e;
        lg_ring[lp] = e;
        sh_wr = (sp + 1 == sw) ? '0 : SHORT_AW'(sp + 1);
        lg_wr = (lp + 1 == lw) ? '0 : LONG_AW'(lp + 1);
        if (seen_frames < lw) seen_frames = seen_frames + 1'b1;

        since = now - last_hit_ms;
        if (seen_frames < reg_warmup) return EV_NONE;
        if (last_hit_ms != 0 && since < reg_cooldown) return EV_NONE;
        if (lg_sum == 0) return EV_NONE;

        n_l = 64'(seen_frames);
        n_s = (seen_frames < sw) ? 64'(seen_frames) : 64'(sw);
        a = 64'(sh_sum) * n_l;
        b = 64'(lg_sum) * n_s;
        if (a <= b) drop_ready = 1'b1;
        if (a >= b) brk_ready = 1'b1;
        ev = EV_NONE;
        if ((a << 8) > 64'(reg_drop) * b && drop_ready)
        begin
            ev = EV_DROP;
            drop_ready = 1'b0;
        end
        else if ((a << 8) < 64'(reg_brk) * b && brk_ready)
        begin
            ev = EV_BREAKDOWN;
            brk_ready = 1'b0;
        end
        if (ev != EV_NONE) last_hit_ms = now;
        return ev;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] with_noise_bits(input logic [CFG_DATA_W-1:0] v,
                                                              input int w);
        logic [CFG_DATA_W-1:0] r;
        r = $urandom();
        if (w >= CFG_DATA_W) return v;
        return (r << w) | (v & ((32'd1 << w) - 1));
    endfunction

    task automatic drain_results();
        in_ch.valid = 1'b0;
        while (pending_events.size() != 0) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_index = idx;
        cfg_data  = value;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic apply_settings(input logic [31:0] sw, input logic [31:0] lw,
                                  input logic [31:0] wu, input logic [31:0] cd,
                                  input logic [31:0] dr, input logic [31:0] br);
        write_register(CFG_SHORT_WINDOW, with_noise_bits(sw, SWIN_W));
        write_register(CFG_LONG_WINDOW, with_noise_bits(lw, CNT_W));
        write_register(CFG_WARMUP_FRAMES, with_noise_bits(wu, CNT_W));
        write_register(CFG_COOLDOWN_MS, with_noise_bits(cd, TIME_W));
        write_register(CFG_DROP_RATIO, with_noise_bits(dr, RATIO_W));
        write_register(CFG_BREAKDOWN_RATIO, with_noise_bits(br, RATIO_W));
    endtask

    task automatic send_frame(input logic [ENERGY_W-1:0] e, input logic [TIME_W-1:0] t,
                              input chk_t chk, input logic [EVENT_W-1:0] ev);
        int gap;
        int r;
        gap = 0;
        if (tx_idle_on)
        begin
            r = $urandom_range(0, 15);
            if (r >= 15) gap = $urandom_range(20, 60);
            else if (r >= 9) gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.energy  = e;
        in_ch.time_ms = t;
        row_chk       = chk;
        row_ev        = ev;
        in_ch.valid   = 1'b1;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        logic [EVENT_W-1:0] want;
        logic [EVENT_W-1:0] got;
        if (!rst_n)
        begin
            reg_short_win = RST_SHORT_WINDOW;
            reg_long_win  = RST_LONG_WINDOW;
            reg_warmup    = RST_WARMUP_FRAMES;
            reg_cooldown  = RST_COOLDOWN_MS;
            reg_drop      = RST_DROP_RATIO;
            reg_brk       = RST_BREAKDOWN_RATIO;
            clear_detector();
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_events.size() == 0)
                begin
                    err_count++;
                    $display("%0t: event %0d with no frame pending", $time, out_ch.event_res);
                end
                else
                begin
                    want = pending_events.pop_front();
                    if (out_ch.event_res !== want)
                    begin
                        err_count++;
                        $display("%0t: event_res mismatch: expected %0d, actual %0d",
                                 $time, want, out_ch.event_res);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                got = predict_event(in_ch.energy, in_ch.time_ms);
                pending_events.push_back(row_chk == CHK_FIXED ? row_ev : got);
            end
            if (cfg_we) apply_register(cfg_index, cfg_data);
        end
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("** energy_drop_breakdown_detector: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int stall_left;
        int hold_left;
        bit hold_done;
        stall_left   = 0;
        hold_done    = 1'b0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                out_ch.ready = 1'b0;
                hold_left = HOLD_CYCLES;
                while (hold_left > 0)
                begin
                    @(negedge clk);
                    hold_left--;
                end
                hold_done = 1'b1;
            end
            if (stall_left > 0)
            begin
                out_ch.ready = 1'b0;
                stall_left--;
            end
            else if (rx_idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 3);
                out_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready = 1'b1;
            end
        end
    end

    initial
    begin
        dir_row_t          row;
        int                sent;
        int                n_items;
        int                seg_left;
        int                level;
        int                val;
        int                r;
        logic [TIME_W-1:0] stamp;
        logic [31:0]       sw_v;
        logic [31:0]       lw_v;
        logic [31:0]       wu_v;
        logic [31:0]       cd_v;
        logic [31:0]       dr_v;
        logic [31:0]       br_v;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_SHORT_WINDOW;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.energy  = '0;
        in_ch.time_ms = '0;
        row_chk       = CHK_MODEL;
        row_ev        = EV_NONE;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        hold_req      = 1'b0;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        for (int k = 0; k < DIR_N; k++)
        begin
            row = DIR_ROWS[k];
            if (row.kind == ROW_REG) write_register(row.idx, row.value);
            else send_frame(row.energy, row.stamp, row.chk, row.ev);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0: apply_settings(0, 0, 0, 0, 0, 0);
                1: apply_settings(31, 1023, 1023, 32'hFFFF_FFFF, 4095, 4095);
                default:
                begin
                    r = $urandom_range(0, 7);
                    sw_v = (r == 0) ? 0 : (r == 1) ? 31 : (r == 2) ? 16 : $urandom_range(1, 12);
                    r = $urandom_range(0, 7);
                    lw_v = (r == 0) ? 0 : (r == 1) ? $urandom_range(0, 1023) :
                           (r == 2) ? 1 : $urandom_range(2, 40);
                    r = $urandom_range(0, 7);
                    wu_v = (r == 0) ? 1023 : (r == 1) ? 0 : $urandom_range(0, 20);
                    r = $urandom_range(0, 7);
                    cd_v = (r == 0) ? 0 : (r == 1) ? 32'hFFFF_FFFF :
                           (r == 2) ? $urandom() : $urandom_range(1, 400);
                    r = $urandom_range(0, 7);
                    dr_v = (r == 0) ? 0 : (r == 1) ? 4095 :
                           (r == 2) ? $urandom_range(0, 4095) : $urandom_range(260, 700);
                    r = $urandom_range(0, 7);
                    br_v = (r == 0) ? 0 : (r == 1) ? 4095 :
                           (r == 2) ? $urandom_range(0, 4095) : $urandom_range(60, 250);
                    apply_settings(sw_v, lw_v, wu_v, cd_v, dr_v, br_v);
                end
            endcase

            tx_idle_on = (p != 2) && ($urandom_range(0, 3) != 0);
            rx_idle_on = (p != 2) && ($urandom_range(0, 3) != 0);
            n_items    = (p == 1) ? 30 : 64;
            stamp      = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000)
                                                     : $urandom();
            sent       = 0;
            seg_left   = 0;
            level      = 0;
            while (sent < n_items)
            begin
                if (p == 3 && sent == 10) hold_req = 1'b1;
                if (p == 5 && sent == 20) drain_results();
                if (seg_left == 0 && $urandom_range(0, 9) == 0)
                begin
                    send_frame(16'($urandom()), $urandom(), CHK_MODEL, EV_NONE);
                end
                else
                begin
                    if (seg_left == 0)
                    begin
                        r = $urandom_range(0, 9);
                        level = (r == 0) ? 0 :
                                (r == 1) ? int'($urandom_range(60000, 65535)) :
                                int'($urandom_range(200, 20000));
                        seg_left = $urandom_range(2, 24);
                    end
                    seg_left--;
                    val = level - level / 16 + int'($urandom_range(0, level / 8));
                    if (val > 65535) val = 65535;
                    stamp = stamp + $urandom_range(5, 80);
                    send_frame(16'(val), stamp, CHK_MODEL, EV_NONE);
                end
                sent++;
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (err_count == 0 && pending_events.size() == 0)
        begin
            $display("** energy_drop_breakdown_detector: PASSED **");
        end
        else
        begin
            $display("** energy_drop_breakdown_detector: FAILED **");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/edbd_pkg.sv
rtl/edbd_if.sv
rtl/edbd_ram.sv
rtl/energy_drop_breakdown_detector.sv
test/testbench.sv
